@@ hdl/page_buffer_pool_manager_assert.svh @@
// Assertion macros for the page buffer pool manager
`ifndef PAGE_BUFFER_POOL_MANAGER_ASSERT_SVH
`define PAGE_BUFFER_POOL_MANAGER_ASSERT_SVH

// Check that a condition always implies a consequence on the same edge
`define PBPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbpm check failed");

// Check that a condition implies a consequence on the next edge
`define PBPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbpm check failed");

`endif

@@ hdl/pbpm_pkg.sv @@
`default_nettype none
package pbpm_pkg;
  localparam int FRAMES       = 16;
  localparam int PAGE_ID_BITS = 32;
  localparam int PIN_BITS     = 8;
  localparam int FIDX_BITS    = $clog2(FRAMES);
  localparam int CNT_BITS     = $clog2(FRAMES + 1);

  typedef logic [FIDX_BITS-1:0]    fidx_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [PAGE_ID_BITS-1:0] page_t;
  typedef logic [PIN_BITS-1:0]     pins_t;

  typedef enum logic [2:0] {
    CMD_NEW    = 3'd0,
    CMD_FETCH  = 3'd1,
    CMD_UNPIN  = 3'd2,
    CMD_FLUSH  = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  localparam pins_t PIN_MAX = {PIN_BITS{1'b1}};

  // Request to the LRU list unit and its status back
  typedef struct packed {
    logic  rem;
    logic  app;
    fidx_t frame;
  } lru_req_t;

  typedef struct packed {
    logic busy;
    cnt_t count;
    fidx_t oldest;
  } lru_sts_t;
endpackage
`default_nettype wire

@@ hdl/pbpm_lru.sv @@
`default_nettype none
// LRU list of unpinned frames, oldest at position 0. Removal shifts one
// entry per cycle; append removes any existing copy first.
module pbpm_lru import pbpm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lru_req_t req,
  output lru_sts_t      sts
);
  typedef enum logic [1:0] {L_IDLE, L_SCAN, L_SHIFT, L_ADD} lstate_t;

  lstate_t state_r;
  fidx_t   order_r [FRAMES];
  cnt_t    count_r;
  cnt_t    pos_r;
  fidx_t   tgt_r;
  logic    app_r;

  assign sts.busy   = (state_r != L_IDLE);
  assign sts.count  = count_r;
  assign sts.oldest = order_r[0];

  // Sequence scan, shift and append over the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      count_r <= '0;
      pos_r   <= '0;
      app_r   <= 1'b0;
    end else begin
      unique case (state_r)
        L_IDLE: begin
          if (req.rem || req.app) begin
            tgt_r   <= req.frame;
            app_r   <= req.app;
            pos_r   <= '0;
            state_r <= L_SCAN;
          end
        end
        L_SCAN: begin
          if (pos_r >= count_r) begin
            state_r <= app_r ? L_ADD : L_IDLE;
          end else if (order_r[pos_r[FIDX_BITS-1:0]] == tgt_r) begin
            state_r <= L_SHIFT;
          end else begin
            pos_r <= pos_r + cnt_t'(1);
          end
        end
        L_SHIFT: begin
          if (pos_r + cnt_t'(1) < count_r) begin
            order_r[pos_r[FIDX_BITS-1:0]] <= order_r[FIDX_BITS'(pos_r + cnt_t'(1))];
            pos_r <= pos_r + cnt_t'(1);
          end else begin
            count_r <= count_r - cnt_t'(1);
            state_r <= app_r ? L_ADD : L_IDLE;
          end
        end
        L_ADD: begin
          if (count_r < cnt_t'(FRAMES)) begin
            order_r[count_r[FIDX_BITS-1:0]] <= tgt_r;
            count_r <= count_r + cnt_t'(1);
          end
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/page_buffer_pool_manager.sv @@
`default_nettype none
// Page buffer pool manager with LRU replacement.
// The frame search visits one frame a cycle and the LRU list shifts one entry a
// cycle. One request is handled at a time: in_stall stays high until the result
// has been taken while out_stall is low.
// Reset (synchronous, active low): all frames free in order, LRU list empty.
module page_buffer_pool_manager import pbpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire page_t       in_page_id,
  input  wire logic        in_mark_dirty,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output fidx_t            out_frame,
  output logic             out_write_back,
  output page_t            out_write_back_page,
  output logic             out_read_request,
  output logic             out_dealloc_request
);
  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_ACT, S_TAKE, S_WAIT, S_DONE}
    state_t;

  state_t   state_r;
  logic     valid_r [FRAMES];
  logic     dirty_r [FRAMES];
  pins_t    pins_r  [FRAMES];
  page_t    page_r  [FRAMES];
  fidx_t    fq_r    [FRAMES];
  fidx_t    fhead_r;
  cnt_t     fcount_r;
  logic [2:0] cmd_r;
  page_t    id_r;
  logic     md_r;
  cnt_t     idx_r;
  logic     hit_r;
  fidx_t    hf_r;
  fidx_t    tf_r;
  logic     tvalid_r;
  lru_req_t lreq;
  lru_sts_t lsts;
  logic     ok_r, wb_r, rd_r, da_r;
  fidx_t    fr_r;
  page_t    wbp_r;
  fidx_t    cur;

  pbpm_lru u_lru (.clk(clk), .rst_n(rst_n), .req(lreq), .sts(lsts));

  assign cur      = idx_r[FIDX_BITS-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_ok = ok_r;
  assign out_frame = fr_r;
  assign out_write_back = wb_r;
  assign out_write_back_page = wbp_r;
  assign out_read_request = rd_r;
  assign out_dealloc_request = da_r;

  // Issue LRU requests from the action step and, on eviction, from the frame take
  always_comb begin
    lreq = '0;
    if (state_r == S_ACT) begin
      lreq.frame = hf_r;
      unique case (cmd_r)
        CMD_FETCH:  lreq.rem = hit_r;
        CMD_UNPIN:  lreq.app = hit_r && pins_r[hf_r] == pins_t'(1);
        CMD_DELETE: lreq.rem = hit_r && pins_r[hf_r] == '0;
        default: ;
      endcase
    end else if (state_r == S_TAKE && fcount_r == '0 && lsts.count != '0) begin
      lreq.rem   = 1'b1;
      lreq.frame = lsts.oldest;
    end
  end

  // Sequence search, action, frame take, LRU wait and result hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fhead_r  <= '0;
      fcount_r <= cnt_t'(FRAMES);
      for (int i = 0; i < FRAMES; i++) begin
        valid_r[i] <= 1'b0;
        dirty_r[i] <= 1'b0;
        pins_r[i]  <= '0;
        fq_r[i]    <= fidx_t'(i);
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_cmd;
            id_r  <= in_page_id;
            md_r  <= in_mark_dirty;
            idx_r <= '0;
            hit_r <= 1'b0;
            ok_r <= 1'b0; fr_r <= '0; wb_r <= 1'b0; wbp_r <= '0;
            rd_r <= 1'b0; da_r <= 1'b0;
            state_r <= (in_cmd == CMD_NEW) ? S_TAKE : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (idx_r >= cnt_t'(FRAMES)) begin
            state_r <= S_ACT;
          end else if (valid_r[cur] && page_r[cur] == id_r) begin
            hit_r   <= 1'b1;
            hf_r    <= cur;
            state_r <= S_ACT;
          end else begin
            idx_r <= idx_r + cnt_t'(1);
          end
        end
        S_ACT: begin
          state_r <= S_WAIT;
          unique case (cmd_r)
            CMD_FETCH: begin
              if (hit_r) begin
                if (pins_r[hf_r] != PIN_MAX) pins_r[hf_r] <= pins_r[hf_r] + pins_t'(1);
                ok_r <= 1'b1;
                fr_r <= hf_r;
              end else begin
                state_r <= S_TAKE;
              end
            end
            CMD_UNPIN: begin
              if (hit_r) begin
                dirty_r[hf_r] <= md_r;
                if (pins_r[hf_r] != '0) begin
                  pins_r[hf_r] <= pins_r[hf_r] - pins_t'(1);
                  ok_r <= 1'b1;
                end
              end
            end
            CMD_FLUSH: begin
              if (hit_r) begin
                ok_r <= 1'b1; wb_r <= 1'b1; wbp_r <= id_r;
              end
            end
            CMD_DELETE: begin
              if (!hit_r || pins_r[hf_r] == '0) begin
                ok_r <= 1'b1; da_r <= 1'b1;
                if (hit_r) begin
                  dirty_r[hf_r] <= 1'b0;
                  valid_r[hf_r] <= 1'b0;
                  if (fcount_r < cnt_t'(FRAMES)) begin
                    fq_r[FIDX_BITS'(cnt_t'(fhead_r) + fcount_r)] <= hf_r;
                    fcount_r <= fcount_r + cnt_t'(1);
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_TAKE: begin
          // Free queue first, then evict the oldest unpinned frame
          state_r <= S_WAIT;
          if (fcount_r != '0) begin
            tf_r <= fq_r[fhead_r];
            fhead_r <= fhead_r + fidx_t'(1);
            fcount_r <= fcount_r - cnt_t'(1);
            tvalid_r <= 1'b1;
          end else if (lsts.count != '0) begin
            tf_r <= lsts.oldest;
            tvalid_r <= 1'b1;
            if (valid_r[lsts.oldest] && dirty_r[lsts.oldest]) begin
              wb_r <= 1'b1;
              wbp_r <= page_r[lsts.oldest];
            end
          end else begin
            tvalid_r <= 1'b0;
          end
          hit_r <= 1'b1;
        end
        S_WAIT: begin
          if (!lsts.busy) begin
            state_r <= S_DONE;
            if (hit_r && ((cmd_r == CMD_NEW) || (cmd_r == CMD_FETCH && !ok_r))
                && tvalid_r && idx_r != '1) begin
              valid_r[tf_r] <= 1'b1;
              page_r[tf_r]  <= id_r;
              dirty_r[tf_r] <= 1'b0;
              if (pins_r[tf_r] != PIN_MAX) pins_r[tf_r] <= pins_r[tf_r] + pins_t'(1);
              ok_r <= 1'b1;
              fr_r <= tf_r;
              rd_r <= (cmd_r == CMD_FETCH);
            end
          end
        end
        S_DONE: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "page_buffer_pool_manager_assert.svh"
  `PBPM_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
  `PBPM_ASSERT_IMP(a_fq_bound, 1'b1, fcount_r <= cnt_t'(FRAMES))
  `PBPM_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_frame))
endmodule
`default_nettype wire
